[hdl/adbpd_pkg.sv]
package adbpd_pkg;

    localparam int DUR_W   = 24;
    localparam int CFG_W   = 24;
    localparam int CIDX_W  = 8;
    localparam int MAX_RES = 3;

    localparam logic [3:0] K_LOW       = 4'd0;
    localparam logic [3:0] K_HIGH      = 4'd1;
    localparam logic [3:0] K_ATTENTION = 4'd2;
    localparam logic [3:0] K_BUS_RESET = 4'd3;
    localparam logic [3:0] K_SRQ       = 4'd4;
    localparam logic [3:0] K_BIT       = 4'd5;
    localparam logic [3:0] K_START     = 4'd6;
    localparam logic [3:0] K_STOP      = 4'd7;
    localparam logic [3:0] K_DATA      = 4'd8;
    localparam logic [3:0] K_CMD_RESET = 4'd9;
    localparam logic [3:0] K_FLUSH     = 4'd10;
    localparam logic [3:0] K_LISTEN    = 4'd11;
    localparam logic [3:0] K_TALK      = 4'd12;
    localparam logic [3:0] K_UNKNOWN   = 4'd13;

    localparam logic [CIDX_W-1:0] REG_SHORT_PULSE = 8'd0;
    localparam logic [CIDX_W-1:0] REG_BIT_CELL    = 8'd1;
    localparam logic [CIDX_W-1:0] REG_ATTENTION   = 8'd2;
    localparam logic [CIDX_W-1:0] REG_BUS_RESET   = 8'd3;

    localparam logic [CFG_W-1:0] RST_SHORT_PULSE = 24'd100;
    localparam logic [CFG_W-1:0] RST_BIT_CELL    = 24'd130;
    localparam logic [CFG_W-1:0] RST_ATTENTION   = 24'd500;
    localparam logic [CFG_W-1:0] RST_BUS_RESET   = 24'd1500;

    localparam logic [3:0]       AWAIT_START = 4'd8;
    localparam logic [DUR_W-1:0] DUR_MAX     = 24'hFFFFFF;

    typedef struct packed {
        logic [CFG_W-1:0] short_pulse;
        logic [CFG_W-1:0] bit_cell;
        logic [CFG_W-1:0] attention;
        logic [CFG_W-1:0] bus_reset;
    } t_cfg;

    typedef struct packed {
        logic [3:0]       kind;
        logic [DUR_W-1:0] duration;
        logic             bit_value;
        logic [7:0]       byte_value;
        logic [3:0]       address;
        logic [1:0]       register_number;
        logic             last;
    } t_result;

    typedef t_result [MAX_RES-1:0] t_result_set;

    typedef struct packed {
        logic       load;
        logic [1:0] count;
    } t_load;

endpackage

[hdl/adbpd_cfg.sv]
module adbpd_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [adbpd_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [adbpd_pkg::CFG_W-1:0]    i_cfg_data,
    output adbpd_pkg::t_cfg                o_cfg
);
    import adbpd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_pulse <= RST_SHORT_PULSE;
            r_cfg.bit_cell    <= RST_BIT_CELL;
            r_cfg.attention   <= RST_ATTENTION;
            r_cfg.bus_reset   <= RST_BUS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SHORT_PULSE: r_cfg.short_pulse <= i_cfg_data;
                REG_BIT_CELL:    r_cfg.bit_cell    <= i_cfg_data;
                REG_ATTENTION:   r_cfg.attention   <= i_cfg_data;
                REG_BUS_RESET:   r_cfg.bus_reset   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/adbpd_core.sv]
module adbpd_core #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_fire,
    input  logic                    i_level,
    input  adbpd_pkg::t_cfg         i_cfg,
    output adbpd_pkg::t_result_set  o_res,
    output logic [1:0]              o_count
);
    import adbpd_pkg::*;

    localparam int EW = ((COUNT_WIDTH > DUR_W) ? COUNT_WIDTH : DUR_W) + 1;
    localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

    logic                   r_synced, n_synced;
    logic                   r_prev;
    logic [COUNT_WIDTH-1:0] r_pc, n_pc;
    logic [COUNT_WIDTH-1:0] r_low, n_low;
    logic [3:0]             r_bit_phase, n_bit_phase;
    logic                   r_attn, n_attn;
    logic [7:0]             r_shift, n_shift;

    logic                   rising, falling, b, low_short;
    logic [COUNT_WIDTH-1:0] pc_inc;
    logic [EW-1:0]          pc_e, low_e, cell_e, cmax_e, dmax_e;
    logic [EW-1:0]          sp_e, bc_e, at_e, br_e;
    logic [DUR_W-1:0]       pc_dur;
    logic [7:0]             shifted;
    logic [3:0]             cmd_kind;
    t_result_set            res;
    logic [1:0]             cnt;

    always_comb begin
        rising  = !r_prev && i_level;
        falling = r_prev && !i_level;
        pc_inc  = (r_pc == CMAX) ? r_pc : r_pc + 1'b1;
        pc_e    = EW'(pc_inc);
        low_e   = EW'(r_low);
        cmax_e  = EW'(CMAX);
        dmax_e  = EW'(DUR_MAX);
        sp_e    = EW'(i_cfg.short_pulse);
        bc_e    = EW'(i_cfg.bit_cell);
        at_e    = EW'(i_cfg.attention);
        br_e    = EW'(i_cfg.bus_reset);
        cell_e  = low_e + pc_e;
        if (cell_e > cmax_e) begin
            cell_e = cmax_e;
        end
        pc_dur    = (pc_e > dmax_e) ? DUR_MAX : pc_e[DUR_W-1:0];
        low_short = low_e < sp_e;
        b         = (r_low > pc_inc) ? 1'b0 : 1'b1;
        shifted   = {r_shift[6:0], b};
        case (shifted[3:0]) inside
            4'd0:            cmd_kind = K_CMD_RESET;
            4'd1:            cmd_kind = K_FLUSH;
            [4'd8:4'd11]:    cmd_kind = K_LISTEN;
            [4'd12:4'd15]:   cmd_kind = K_TALK;
            default:         cmd_kind = K_UNKNOWN;
        endcase
    end

    always_comb begin
        n_synced    = r_synced;
        n_pc        = r_pc;
        n_low       = r_low;
        n_bit_phase = r_bit_phase;
        n_attn      = r_attn;
        n_shift     = r_shift;
        res         = '0;
        cnt         = 2'd0;
        if (!r_synced) begin
            if (falling) begin
                n_synced = 1'b1;
                n_pc     = '0;
            end
        end else begin
            n_pc = pc_inc;
            if (rising) begin
                n_low           = pc_inc;
                n_pc            = '0;
                cnt             = 2'd1;
                res[0].duration = pc_dur;
                if (pc_e < sp_e) begin
                    res[0].kind = K_LOW;
                end else if (pc_e > br_e) begin
                    res[0].kind = K_BUS_RESET;
                end else if (pc_e > at_e) begin
                    res[0].kind = K_ATTENTION;
                    n_attn      = 1'b1;
                end else begin
                    res[0].kind = K_SRQ;
                end
            end else if (falling) begin
                n_pc = '0;
                if (pc_e < sp_e) begin
                    res[0].kind     = K_HIGH;
                    res[0].duration = pc_dur;
                    cnt             = 2'd2;
                    if (cell_e <= bc_e) begin
                        if (r_bit_phase >= AWAIT_START) begin
                            n_bit_phase      = 4'd0;
                            res[1].kind      = K_START;
                            res[1].bit_value = 1'b1;
                        end else begin
                            res[1].kind      = K_BIT;
                            res[1].bit_value = b;
                            n_shift          = shifted;
                            n_bit_phase      = {1'b0, r_bit_phase[2:0] + 3'd1};
                            if (r_bit_phase[2:0] == 3'd7) begin
                                cnt               = 2'd3;
                                res[2].byte_value = shifted;
                                if (r_attn) begin
                                    res[2].kind            = cmd_kind;
                                    res[2].address         = shifted[7:4];
                                    res[2].register_number = shifted[1:0];
                                    n_attn                 = 1'b0;
                                    n_bit_phase            = AWAIT_START;
                                end else begin
                                    res[2].kind = K_DATA;
                                end
                            end
                        end
                    end else if (low_short) begin
                        res[1].kind = K_STOP;
                    end else begin
                        res[1].kind      = K_START;
                        res[1].bit_value = 1'b1;
                        n_bit_phase      = 4'd0;
                    end
                end else if (low_short) begin
                    res[0].kind = K_STOP;
                    cnt         = 2'd1;
                end
            end
        end
        if (cnt != 2'd0) begin
            res[2'(cnt - 2'd1)].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_synced    <= 1'b0;
            r_prev      <= 1'b0;
            r_pc        <= '0;
            r_low       <= '0;
            r_bit_phase <= 4'd0;
            r_attn      <= 1'b0;
            r_shift     <= 8'd0;
        end else if (i_fire) begin
            r_synced    <= n_synced;
            r_prev      <= i_level;
            r_pc        <= n_pc;
            r_low       <= n_low;
            r_bit_phase <= n_bit_phase;
            r_attn      <= n_attn;
            r_shift     <= n_shift;
        end
    end

    assign o_res   = res;
    assign o_count = cnt;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_synced |-> (r_pc == '0 && r_bit_phase == 4'd0 && !r_attn))
        else $error("state moved before sync");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_phase <= AWAIT_START)
        else $error("bit phase out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cnt != 2'd0) |-> (r_synced && (rising || falling)))
        else $error("events without a line edge");

endmodule

[hdl/adbpd_outbuf.sv]
module adbpd_outbuf (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  adbpd_pkg::t_load        i_load,
    input  adbpd_pkg::t_result_set  i_res,
    input  logic                    i_stall,
    output logic                    o_free,
    output logic                    o_valid,
    output adbpd_pkg::t_result      o_res
);
    import adbpd_pkg::*;

    t_result_set r_entries;
    logic [1:0]  r_count;
    logic [1:0]  r_rd;
    logic        pop;

    assign pop     = (r_count != 2'd0) && !i_stall;
    assign o_free  = (r_count == 2'd0) || (r_count == 2'd1 && !i_stall);
    assign o_valid = r_count != 2'd0;
    assign o_res   = r_entries[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_rd    <= 2'd0;
        end else if (i_load.load) begin
            r_count <= i_load.count;
            r_rd    <= 2'd0;
        end else if (pop) begin
            r_count <= r_count - 2'd1;
            r_rd    <= r_rd + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            r_entries <= i_res;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_rd} + {1'b0, r_count}) <= 3'd3)
        else $error("read pointer beyond stored requests");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.last) |-> (r_count == 2'd1))
        else $error("last flag not on final request");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load.load |-> o_free)
        else $error("load into occupied buffer");

endmodule

[hdl/adb_bus_pulse_decoder_unit.sv]
// Bus data line pulse decoder.
// Input channel: one line sample per request on i_line_level, i_valid/o_stall.
// Output channel: event requests on o_event_kind and the other o_* fields,
// o_valid/i_stall; o_last marks the final event caused by one sample.
// Config channel: i_cfg_valid/o_cfg_ready (always ready), i_cfg_index 0..3
// selects short pulse, bit cell, attention and bus reset thresholds;
// other indexes are ignored. Write only while the block is idle.
// Path: a sample is held in the input register, and its events are loaded
// into the output register once the event buffer is free.
// Throughput: one sample per cycle while each sample causes at most one
// event and the output is not stalled. A sample causing several events holds
// the input while the single output port drains the event buffer one request per cycle when not stalled.
// Reset: thresholds return to 100, 130, 500 and 1500 ticks, the decoder
// waits for the first falling edge again, and pending events are dropped.
// Output stall: events hold steady, the buffer stops draining and o_stall
// rises once the sample in the input register cannot be processed.
module adb_bus_pulse_decoder_unit #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_line_level,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [3:0]                     o_event_kind,
    output logic [adbpd_pkg::DUR_W-1:0]    o_duration,
    output logic                           o_bit_value,
    output logic [7:0]                     o_byte_value,
    output logic [3:0]                     o_device_address,
    output logic [1:0]                     o_register_number,
    output logic                           o_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [adbpd_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [adbpd_pkg::CFG_W-1:0]    i_cfg_data
);
    import adbpd_pkg::*;

    logic        r_in_valid;
    logic        r_level;
    logic        free;
    logic        fire;
    logic [1:0]  count;
    t_cfg        cfg;
    t_result_set res;
    t_result     out_res;
    t_load       load;

    assign fire      = r_in_valid && free;
    assign o_stall   = r_in_valid && !free;
    assign load.load = fire && (count != 2'd0);
    assign load.count = count;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_level <= i_line_level;
        end
    end

    adbpd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    adbpd_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_level (r_level),
        .i_cfg   (cfg),
        .o_res   (res),
        .o_count (count)
    );

    adbpd_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_res   (res),
        .i_stall (i_stall),
        .o_free  (free),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_event_kind      = out_res.kind;
    assign o_duration        = out_res.duration;
    assign o_bit_value       = out_res.bit_value;
    assign o_byte_value      = out_res.byte_value;
    assign o_device_address  = out_res.address;
    assign o_register_number = out_res.register_number;
    assign o_last            = out_res.last;

endmodule

[test/adb_bus_pulse_decoder_unit_test.sv]
`timescale 1ns / 1ps

module adb_bus_pulse_decoder_unit_test;
    import adbpd_pkg::*;

    localparam logic [CIDX_W-1:0] REG_SPARE_LO = 8'd4;
    localparam logic [CIDX_W-1:0] REG_SPARE_HI = 8'hFF;
    localparam logic [CFG_W-1:0]  CFG_MAX      = 24'hFFFFFF;
    localparam int                HOLD_CYCLES  = 60;

    class pulse_scoreboard;
        t_cfg             thr;
        bit               synced;
        bit               prev_level;
        bit               attn_pending;
        logic [DUR_W-1:0] phase_cnt;
        logic [DUR_W-1:0] low_len;
        logic [3:0]       bit_phase;
        logic [7:0]       shift_byte;
        t_result          step_events[$];
        t_result          awaited[$];
        int               errors;
        int               samples;
        int               events;

        function new();
            thr.short_pulse = RST_SHORT_PULSE;
            thr.bit_cell    = RST_BIT_CELL;
            thr.attention   = RST_ATTENTION;
            thr.bus_reset   = RST_BUS_RESET;
            synced       = 1'b0;
            prev_level   = 1'b0;
            attn_pending = 1'b0;
            phase_cnt    = '0;
            low_len      = '0;
            bit_phase    = '0;
            shift_byte   = '0;
            errors       = 0;
            samples      = 0;
            events       = 0;
        endfunction

        function void set_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_SHORT_PULSE: thr.short_pulse = val;
                REG_BIT_CELL:    thr.bit_cell    = val;
                REG_ATTENTION:   thr.attention   = val;
                REG_BUS_RESET:   thr.bus_reset   = val;
                default: ;
            endcase
        endfunction

        function void add(logic [3:0] kind, logic [DUR_W-1:0] dur, bit bv, logic [7:0] byv);
            t_result r;
            r = '0;
            r.kind       = kind;
            r.duration   = dur;
            r.bit_value  = bv;
            r.byte_value = byv;
            if (kind >= K_CMD_RESET) begin
                r.address         = byv[7:4];
                r.register_number = byv[1:0];
            end
            step_events.push_back(r);
        endfunction

        function logic [3:0] command_kind(logic [7:0] c);
            if (c[3:0] == 4'd0)
                return K_CMD_RESET;
            else if (c[3:0] == 4'd1)
                return K_FLUSH;
            else if (c[3:2] == 2'b10)
                return K_LISTEN;
            else if (c[3:2] == 2'b11)
                return K_TALK;
            return K_UNKNOWN;
        endfunction

        function void note(bit lvl);
            bit               rising;
            bit               falling;
            bit               low_short;
            bit               b;
            logic [DUR_W-1:0] low;
            logic [DUR_W-1:0] high;
            logic [DUR_W:0]   cell_len;
            rising     = !prev_level && lvl;
            falling    = prev_level && !lvl;
            prev_level = lvl;
            samples++;
            step_events.delete();
            if (!synced) begin
                if (falling) begin
                    synced    = 1'b1;
                    phase_cnt = '0;
                end
                return;
            end
            if (phase_cnt != DUR_MAX)
                phase_cnt++;
            if (rising) begin
                low       = phase_cnt;
                low_len   = low;
                phase_cnt = '0;
                if (low < thr.short_pulse) begin
                    add(K_LOW, low, 1'b0, 8'd0);
                end else if (low > thr.bus_reset) begin
                    add(K_BUS_RESET, low, 1'b0, 8'd0);
                end else if (low > thr.attention) begin
                    add(K_ATTENTION, low, 1'b0, 8'd0);
                    attn_pending = 1'b1;
                end else begin
                    add(K_SRQ, low, 1'b0, 8'd0);
                end
            end else if (falling) begin
                high      = phase_cnt;
                low       = low_len;
                cell_len  = {1'b0, low} + {1'b0, high};
                low_short = low < thr.short_pulse;
                if (cell_len > {1'b0, DUR_MAX})
                    cell_len = {1'b0, DUR_MAX};
                phase_cnt = '0;
                if (high < thr.short_pulse) begin
                    add(K_HIGH, high, 1'b0, 8'd0);
                    if (cell_len <= {1'b0, thr.bit_cell}) begin
                        if (bit_phase >= AWAIT_START) begin
                            bit_phase = '0;
                            add(K_START, '0, 1'b1, 8'd0);
                        end else begin
                            b = (low > high) ? 1'b0 : 1'b1;
                            add(K_BIT, '0, b, 8'd0);
                            shift_byte = {shift_byte[6:0], b};
                            bit_phase  = {1'b0, bit_phase[2:0] + 3'd1};
                            if (bit_phase == 4'd0) begin
                                if (attn_pending) begin
                                    add(command_kind(shift_byte), '0, 1'b0, shift_byte);
                                    attn_pending = 1'b0;
                                    bit_phase    = AWAIT_START;
                                end else begin
                                    add(K_DATA, '0, 1'b0, shift_byte);
                                end
                            end
                        end
                    end else if (low_short) begin
                        add(K_STOP, '0, 1'b0, 8'd0);
                    end else begin
                        add(K_START, '0, 1'b1, 8'd0);
                        bit_phase = '0;
                    end
                end else if (low_short) begin
                    add(K_STOP, '0, 1'b0, 8'd0);
                end
            end
            foreach (step_events[i]) begin
                if (i == step_events.size() - 1)
                    step_events[i].last = 1'b1;
                awaited.push_back(step_events[i]);
            end
        endfunction

        function string show(t_result r);
            return $sformatf("kind=%0d dur=%0d bit=%0b byte=%02h addr=%0d reg=%0d last=%0b",
                             r.kind, r.duration, r.bit_value, r.byte_value, r.address,
                             r.register_number, r.last);
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("error: %s", msg);
        endfunction

        function void check(t_result got);
            t_result want;
            events++;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected event %s", show(got)));
                return;
            end
            want = awaited.pop_front();
            if (got !== want)
                report($sformatf("event %0d: expected %s, got %s", events, show(want), show(got)));
        endfunction

        function void finish();
            while (awaited.size() != 0)
                report($sformatf("event never arrived: %s", show(awaited.pop_front())));
        endfunction
    endclass

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_valid      = 1'b0;
    logic                i_line_level = 1'b0;
    logic                i_stall      = 1'b0;
    logic                i_cfg_valid  = 1'b0;
    logic [CIDX_W-1:0]   i_cfg_index  = '0;
    logic [CFG_W-1:0]    i_cfg_data   = '0;
    logic                o_stall;
    logic                o_valid;
    logic [3:0]          o_event_kind;
    logic [DUR_W-1:0]    o_duration;
    logic                o_bit_value;
    logic [7:0]          o_byte_value;
    logic [3:0]          o_device_address;
    logic [1:0]          o_register_number;
    logic                o_last;
    logic                o_cfg_ready;

    pulse_scoreboard sb = new();

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int cfg_writes    = 0;

    adb_bus_pulse_decoder_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_line_level      (i_line_level),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_event_kind      (o_event_kind),
        .o_duration        (o_duration),
        .o_bit_value       (o_bit_value),
        .o_byte_value      (o_byte_value),
        .o_device_address  (o_device_address),
        .o_register_number (o_register_number),
        .o_last            (o_last),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // receiver: random stall, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check({o_event_kind, o_duration, o_bit_value, o_byte_value,
                      o_device_address, o_register_number, o_last});
    end

    task automatic send_sample(input bit lvl);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99, 0) < send_idle_pct)
            gap++;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_line_level <= lvl;
        do @(posedge i_clk); while (o_stall);
        sb.note(lvl);
    endtask

    task automatic send_run(input bit lvl, input int n);
        repeat (n) send_sample(lvl);
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.awaited.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // writes only once the block has gone quiet
    task automatic apply_cfg(input logic [CFG_W-1:0] sp, input logic [CFG_W-1:0] bc,
                             input logic [CFG_W-1:0] at, input logic [CFG_W-1:0] br);
        stop_sending();
        drain();
        repeat (4) @(posedge i_clk);
        write_reg(REG_SHORT_PULSE, sp);
        write_reg(REG_BIT_CELL, bc);
        write_reg(REG_ATTENTION, at);
        write_reg(REG_BUS_RESET, br);
    endtask

    task automatic send_bit(input bit b);
        int sp;
        int bc;
        int lo;
        int hi;
        sp = int'(sb.thr.short_pulse);
        bc = int'(sb.thr.bit_cell);
        do begin
            lo = $urandom_range(sp - 1, 1);
            hi = $urandom_range(sp - 1, 1);
        end while (lo + hi > bc || ((lo > hi) == b));
        send_run(1'b0, lo);
        send_run(1'b1, hi);
    endtask

    task automatic send_stop();
        int sp;
        sp = int'(sb.thr.short_pulse);
        send_run(1'b0, $urandom_range(sp - 1, 1));
        send_run(1'b1, $urandom_range(sp + 3, sp));
    endtask

    // attention, start, command bits, stop, then maybe one data byte
    task automatic send_frame();
        int         sp;
        int         at;
        int         br;
        int         nbits;
        logic [7:0] cmd;
        logic [7:0] dat;
        sp    = int'(sb.thr.short_pulse);
        at    = int'(sb.thr.attention);
        br    = int'(sb.thr.bus_reset);
        nbits = ($urandom_range(9, 0) < 8) ? 8 : $urandom_range(7, 1);
        cmd   = 8'($urandom_range(255, 0));
        case ($urandom_range(4, 0))
            0: cmd[3:0] = 4'd0;
            1: cmd[3:0] = 4'd1;
            2: cmd[3:2] = 2'b10;
            3: cmd[3:2] = 2'b11;
            default: cmd[3:0] = 4'($urandom_range(7, 2));
        endcase
        send_run(1'b0, $urandom_range(br, at + 1));
        send_run(1'b1, $urandom_range(sp - 1, 1));
        for (int i = 0; i < nbits; i++)
            send_bit(cmd[7 - i]);
        send_stop();
        repeat ($urandom_range(1, 0)) begin
            dat = 8'($urandom_range(255, 0));
            send_bit(1'($urandom_range(1, 0)));
            for (int i = 0; i < 8; i++)
                send_bit(dat[7 - i]);
            send_stop();
        end
    endtask

    task automatic run_phase(input int target, input int frames, input int cap);
        int first;
        first = sb.samples;
        repeat (frames) send_frame();
        while (sb.samples - first < target)
            send_run(1'($urandom_range(1, 0)), $urandom_range(cap, 1));
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // tight thresholds: low 1 normal, 2..3 srq, 4..5 attention, above that bus reset
        apply_cfg(24'd2, 24'd3, 24'd3, 24'd5);
        send_run(1'b0, 1);
        send_run(1'b1, 1);
        send_run(1'b0, 6);
        send_run(1'b1, 1);
        send_run(1'b0, 1);
        send_run(1'b1, 2);
        send_run(1'b0, 4);
        send_run(1'b1, 1);
        send_run(1'b0, 2);
        send_run(1'b1, 1);
        send_run(1'b0, 1);
        send_run(1'b1, 1);
        send_run(1'b0, 1);

        apply_cfg(24'd3, 24'd4, 24'd4, 24'd6);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_requests++;
        run_phase(10, 1, 6);

        apply_cfg(24'd3, 24'd5, 24'd6, 24'd9);
        send_idle_pct = 78;
        stall_pct     = 0;
        run_phase(8, 0, 5);

        apply_cfg(24'd3, 24'd4, 24'd4, 24'd6);
        send_idle_pct = 0;
        stall_pct     = 78;
        run_phase(6, 0, 5);
        stop_sending();
        drain();
        run_phase(6, 0, 5);

        apply_cfg(24'd4, 24'd6, 24'd8, 24'd14);
        write_reg(REG_SPARE_LO, 24'd0);
        write_reg(REG_SPARE_HI, CFG_MAX);
        send_idle_pct = 31;
        stall_pct     = 31;
        run_phase(8, 0, 6);

        apply_cfg(24'd1, CFG_MAX, 24'd1, CFG_MAX);
        run_phase(5, 0, 4);

        apply_cfg(CFG_MAX, 24'd1, CFG_MAX, 24'd1);
        send_idle_pct = 0;
        stall_pct     = 0;
        run_phase(5, 0, 4);

        stop_sending();
        drain();
        repeat (10) @(posedge i_clk);
        sb.finish();
        $display("Covered %0d line samples and %0d events under %0d register writes,",
                 sb.samples, sb.events, cfg_writes);
        $display("with frames, noise, threshold extremes and four flow-control patterns");
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout: %0d events still awaited", sb.awaited.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
